### rtl/umi_pkg.sv
package umi_pkg;

	// Field widths of the request and result items
	localparam int LEVEL_W = 5;
	localparam int INDEX_W = 16;
	localparam int ORDER_W = 48;

	// Number of dimensions carried by one request
	localparam int DIMS_MAX = 3;

	// Defaults for the top level parameters
	localparam int DIMS_DEF      = 3;
	localparam int MAX_LEVEL_DEF = 16;

endpackage

### rtl/umi_lane.sv
module umi_lane #(
	parameter int DIMS      = umi_pkg::DIMS_DEF,
	parameter int MAX_LEVEL = umi_pkg::MAX_LEVEL_DEF,
	parameter int LANE      = 0,
	localparam int LVL_W    = $clog2(MAX_LEVEL + 1),
	localparam int IDX_BITS = (MAX_LEVEL < umi_pkg::INDEX_W) ? MAX_LEVEL : umi_pkg::INDEX_W
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic [LVL_W-1:0]            lvl [DIMS],
	input  logic [IDX_BITS-1:0]         idx,
	output logic [umi_pkg::ORDER_W-1:0] word
);

	localparam int POS_W = $clog2(DIMS * MAX_LEVEL + 1);

	logic [POS_W-1:0]    pos_c  [IDX_BITS];
	logic [IDX_BITS-1:0] bit_c;
	logic [POS_W-1:0]    pos_s2 [IDX_BITS];
	logic [IDX_BITS-1:0] bit_s2;

	// Bit b of this dimension lands after every lower bit of all dimensions
	// and after the bit b of the dimensions that sort ahead of this one.
	always_comb begin
		logic [POS_W-1:0] acc;
		for (int b = 0; b < IDX_BITS; b++) begin
			acc = '0;
			for (int e = 0; e < DIMS; e++) begin
				acc = acc + ((lvl[e] < LVL_W'(b)) ? POS_W'(lvl[e]) : POS_W'(b));
				if (e != LANE && lvl[e] > LVL_W'(b) &&
				    (lvl[e] < lvl[LANE] || (lvl[e] == lvl[LANE] && e < LANE))) begin
					acc = acc + POS_W'(1);
				end
			end
			pos_c[b] = acc;
			bit_c[b] = idx[b] & (lvl[LANE] > LVL_W'(b));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s2 <= pos_c;
			bit_s2 <= bit_c;
		end
	end

	// Scatter the kept bits to their places; positions past the top drop out.
	always_comb begin
		word = '0;
		for (int b = 0; b < IDX_BITS; b++) begin
			word = word | (umi_pkg::ORDER_W'(bit_s2[b]) << pos_s2[b]);
		end
	end

endmodule

### rtl/umi_merge.sv
module umi_merge #(
	parameter int DIMS = umi_pkg::DIMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        lane_valid,
	input  logic [umi_pkg::ORDER_W-1:0] lane_word [DIMS],
	output logic                        load,
	output logic                        order_valid,
	input  logic                        order_ready,
	output logic [umi_pkg::ORDER_W-1:0] order_index
);

	logic                        order_valid_q;
	logic [umi_pkg::ORDER_W-1:0] order_q;
	logic [umi_pkg::ORDER_W-1:0] merged;

	always_comb begin
		merged = '0;
		for (int d = 0; d < DIMS; d++) begin
			merged = merged | lane_word[d];
		end
	end

	assign load = !order_valid_q || order_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_valid_q <= 1'b0;
		end else if (load) begin
			order_valid_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && lane_valid) begin
			order_q <= merged;
		end
	end

	assign order_valid = order_valid_q;
	assign order_index = order_q;

endmodule

### rtl/uneven_morton_index_core.sv
// Z-order index over up to three dimensions with unequal bit counts.
//
// Request channel: item_valid/item_ready with level_x/y/z and index_x/y/z.
// Result channel: order_valid/order_ready with order_index, one result for
// every request, in request order.
//
// Levels above MAX_LEVEL saturate; only the low level bits of an index count.
// Dimensions are ranked by ascending level (ties by dimension number) and
// bits are interleaved from bit 0 upward.
//
// Pipeline: stage 1 registers the clipped request, stage 2 holds the bit
// positions computed by one lane per dimension, and the merge stage ORs the
// lanes into the output register, which drives order_valid. A new request is
// taken every cycle while the result channel does not stall.
//
// Each stage advances when it is empty or the next one moves, so a stalled
// receiver fills the pipeline and then drops item_ready. Reset empties all
// stages; the block needs no start-up pass.
module uneven_morton_index_core #(
	parameter int DIMS      = umi_pkg::DIMS_DEF,
	parameter int MAX_LEVEL = umi_pkg::MAX_LEVEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [umi_pkg::LEVEL_W-1:0] level_x,
	input  logic [umi_pkg::LEVEL_W-1:0] level_y,
	input  logic [umi_pkg::LEVEL_W-1:0] level_z,
	input  logic [umi_pkg::INDEX_W-1:0] index_x,
	input  logic [umi_pkg::INDEX_W-1:0] index_y,
	input  logic [umi_pkg::INDEX_W-1:0] index_z,
	output logic                        order_valid,
	input  logic                        order_ready,
	output logic [umi_pkg::ORDER_W-1:0] order_index
);

	localparam int LVL_W    = $clog2(MAX_LEVEL + 1);
	localparam int IDX_BITS = (MAX_LEVEL < umi_pkg::INDEX_W) ? MAX_LEVEL : umi_pkg::INDEX_W;

	logic [umi_pkg::LEVEL_W-1:0] level_all [umi_pkg::DIMS_MAX];
	logic [umi_pkg::INDEX_W-1:0] index_all [umi_pkg::DIMS_MAX];

	logic [LVL_W-1:0]            lvl_s1  [DIMS];
	logic [IDX_BITS-1:0]         idx_s1  [DIMS];
	logic [umi_pkg::ORDER_W-1:0] lane_word [DIMS];
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        ready_s2;
	logic                        merge_load;

	assign level_all[0] = level_x;
	assign level_all[1] = level_y;
	assign level_all[2] = level_z;
	assign index_all[0] = index_x;
	assign index_all[1] = index_y;
	assign index_all[2] = index_z;

	assign ready_s2   = !valid_s2 || merge_load;
	assign item_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Clip levels to MAX_LEVEL and keep only the usable index bits.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			for (int d = 0; d < DIMS; d++) begin
				lvl_s1[d] <= (level_all[d] > umi_pkg::LEVEL_W'(MAX_LEVEL)) ?
				             LVL_W'(MAX_LEVEL) : level_all[d][LVL_W-1:0];
				idx_s1[d] <= index_all[d][IDX_BITS-1:0];
			end
		end
	end

	for (genvar d = 0; d < DIMS; d++) begin : g_lane
		umi_lane #(
			.DIMS      (DIMS),
			.MAX_LEVEL (MAX_LEVEL),
			.LANE      (d)
		) u_lane (
			.clk  (clk),
			.load (ready_s2 && valid_s1),
			.lvl  (lvl_s1),
			.idx  (idx_s1[d]),
			.word (lane_word[d])
		);
	end

	umi_merge #(
		.DIMS (DIMS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lane_valid  (valid_s2),
		.lane_word   (lane_word),
		.load        (merge_load),
		.order_valid (order_valid),
		.order_ready (order_ready),
		.order_index (order_index)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1)
		else $error("stage 1 request lost while stalled");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !merge_load |=> valid_s2)
		else $error("stage 2 request lost while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("request refused with stage 1 empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && order_valid && !order_ready |-> !item_ready)
		else $error("request taken while the pipeline is full and stalled");

endmodule

### verif/uneven_morton_index_core_tb.sv
module uneven_morton_index_core_tb;

	localparam int LEVEL_W   = umi_pkg::LEVEL_W;
	localparam int INDEX_W   = umi_pkg::INDEX_W;
	localparam int ORDER_W   = umi_pkg::ORDER_W;
	localparam int DIM_COUNT = umi_pkg::DIMS_DEF;
	localparam int LEVEL_CAP = umi_pkg::MAX_LEVEL_DEF;

	localparam int RANDOM_PER_PHASE = 235;
	localparam int STALL_LIMIT      = 4000;
	localparam int TAIL_CYCLES      = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0] lx;
		logic [LEVEL_W-1:0] ly;
		logic [LEVEL_W-1:0] lz;
		logic [INDEX_W-1:0] ix;
		logic [INDEX_W-1:0] iy;
		logic [INDEX_W-1:0] iz;
		logic               known;
		logic [ORDER_W-1:0] order;
	} request_row_t;

	localparam int DIRECTED_ROWS = 20;

	// Rows with known set carry a hand-worked order index; the rest use the predictor.
	localparam request_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{5'd0,  5'd0,  5'd0,  16'hffff, 16'hffff, 16'hffff, 1'b1, 48'h0},
		'{5'd16, 5'd16, 5'd16, 16'hffff, 16'hffff, 16'hffff, 1'b1, 48'hffff_ffff_ffff},
		'{5'd31, 5'd31, 5'd31, 16'hffff, 16'hffff, 16'hffff, 1'b1, 48'hffff_ffff_ffff},
		'{5'd16, 5'd0,  5'd0,  16'hffff, 16'hffff, 16'hffff, 1'b1, 48'h0000_0000_ffff},
		'{5'd0,  5'd0,  5'd16, 16'h1234, 16'hffff, 16'habcd, 1'b1, 48'h0000_0000_abcd},
		'{5'd4,  5'd0,  5'd0,  16'hffff, 16'h0000, 16'h0000, 1'b1, 48'hf},
		'{5'd1,  5'd1,  5'd1,  16'h0001, 16'h0000, 16'h0000, 1'b1, 48'h1},
		'{5'd1,  5'd1,  5'd1,  16'h0000, 16'h0001, 16'h0000, 1'b1, 48'h2},
		'{5'd1,  5'd1,  5'd1,  16'h0000, 16'h0000, 16'h0001, 1'b1, 48'h4},
		'{5'd16, 5'd16, 5'd16, 16'hffff, 16'h0000, 16'h0000, 1'b1, 48'h2492_4924_9249},
		'{5'd16, 5'd16, 5'd16, 16'h0000, 16'hffff, 16'h0000, 1'b1, 48'h4924_9249_2492},
		'{5'd16, 5'd16, 5'd16, 16'h0000, 16'h0000, 16'hffff, 1'b1, 48'h9249_2492_4924},
		'{5'd3,  5'd1,  5'd2,  16'h0007, 16'h0001, 16'h0003, 1'b1, 48'h3f},
		'{5'd3,  5'd1,  5'd2,  16'h0001, 16'h0000, 16'h0000, 1'b1, 48'h4},
		'{5'd2,  5'd2,  5'd1,  16'h0000, 16'h0001, 16'h0000, 1'b0, 48'h0},
		'{5'd17, 5'd5,  5'd16, 16'h9e37, 16'h79b9, 16'h7f4a, 1'b0, 48'h0},
		'{5'd16, 5'd15, 5'd16, 16'h0000, 16'hffff, 16'h0000, 1'b0, 48'h0},
		'{5'd0,  5'd16, 5'd16, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, 48'h0},
		'{5'd20, 5'd0,  5'd1,  16'hc3a5, 16'h5a3c, 16'h0001, 1'b0, 48'h0},
		'{5'd16, 5'd16, 5'd16, 16'h5555, 16'haaaa, 16'h5555, 1'b0, 48'h0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [LEVEL_W-1:0] level_x = '0;
	logic [LEVEL_W-1:0] level_y = '0;
	logic [LEVEL_W-1:0] level_z = '0;
	logic [INDEX_W-1:0] index_x = '0;
	logic [INDEX_W-1:0] index_y = '0;
	logic [INDEX_W-1:0] index_z = '0;
	logic               order_valid;
	logic               order_ready = 1'b0;
	logic [ORDER_W-1:0] order_index;

	logic [ORDER_W-1:0] expected_orders [$];
	int                 mismatches = 0;
	int                 send_idle_pct = 33;
	int                 recv_idle_pct = 88;
	int                 quiet_cycles = 0;

	uneven_morton_index_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.level_x     (level_x),
		.level_y     (level_y),
		.level_z     (level_z),
		.index_x     (index_x),
		.index_y     (index_y),
		.index_z     (index_z),
		.order_valid (order_valid),
		.order_ready (order_ready),
		.order_index (order_index)
	);

	always #6 clk = ~clk;

	// Rank dimensions by clipped level (ties by dimension number), then interleave
	// one bit per still-active dimension per round, starting at bit 0.
	function automatic logic [ORDER_W-1:0] morton_index(
		input logic [LEVEL_W-1:0] lx, ly, lz,
		input logic [INDEX_W-1:0] ix, iy, iz
	);
		int                 lvl [3];
		logic [INDEX_W-1:0] idx [3];
		int                 rank [3];
		int                 cur;
		int                 m;
		int                 pos;
		logic [ORDER_W-1:0] acc;
		lvl[0] = lx;
		lvl[1] = ly;
		lvl[2] = lz;
		idx[0] = ix;
		idx[1] = iy;
		idx[2] = iz;
		for (int d = 0; d < 3; d++) begin
			if (lvl[d] > LEVEL_CAP)
				lvl[d] = LEVEL_CAP;
			if (d >= DIM_COUNT)
				lvl[d] = 0;
			rank[d] = d;
		end
		for (int k = 1; k < 3; k++) begin
			cur = rank[k];
			m = k;
			while (m > 0 && lvl[rank[m-1]] > lvl[cur]) begin
				rank[m] = rank[m-1];
				m--;
			end
			rank[m] = cur;
		end
		acc = '0;
		pos = 0;
		for (int b = 0; b < LEVEL_CAP; b++) begin
			for (int k = 0; k < 3; k++) begin
				if (lvl[rank[k]] > b) begin
					if (pos < ORDER_W)
						acc[pos] = idx[rank[k]][b];
					pos++;
				end
			end
		end
		return acc;
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return LEVEL_W'($urandom_range(LEVEL_CAP + 1, (1 << LEVEL_W) - 1));
		else if (sel == 2)
			return LEVEL_W'(LEVEL_CAP);
		else
			return LEVEL_W'($urandom_range(1, LEVEL_CAP));
	endfunction

	// Present one request after a random gap and hold it until accepted.
	task automatic send_request(input request_row_t row);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		level_x <= row.lx;
		level_y <= row.ly;
		level_z <= row.lz;
		index_x <= row.ix;
		index_y <= row.iy;
		index_z <= row.iz;
		do
			@(posedge clk);
		while (!item_ready);
		if (row.known)
			expected_orders.push_back(row.order);
		else
			expected_orders.push_back(morton_index(row.lx, row.ly, row.lz, row.ix, row.iy,
				row.iz));
	endtask

	// Drop valid and hold until every outstanding request has returned.
	task automatic drain_orders();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_orders.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		order_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		logic [ORDER_W-1:0] want;
		if (arst_n && order_valid && order_ready) begin
			if (expected_orders.size() == 0) begin
				$display("%0t: order_index expected none, got %h", $time, order_index);
				mismatches++;
			end else begin
				want = expected_orders.pop_front();
				if (order_index !== want) begin
					$display("%0t: order_index expected %h, got %h", $time, want,
						order_index);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (order_valid && order_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		request_row_t row;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_request(DIRECTED[r]);

		for (int phase = 0; phase < 3; phase++) begin
			// Change idling only with nothing in flight.
			drain_orders();
			case (phase)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				row.lx = pick_level();
				row.ly = pick_level();
				row.lz = pick_level();
				row.ix = INDEX_W'($urandom());
				row.iy = INDEX_W'($urandom());
				row.iz = INDEX_W'($urandom());
				row.known = 1'b0;
				row.order = '0;
				send_request(row);
			end
		end

		drain_orders();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
